>>> design/cpld_pkg.sv
// ----------------------------------------------------------------------------
// Calibrated piecewise-linear drive: shared package
// Types, codes, constants and the default calibration points.
// ----------------------------------------------------------------------------
package cpld_pkg;

	localparam int TABLE_POINTS_DEF = 10;
	localparam int DEF_POINTS = 10;
	localparam logic [15:0] DEF_CUR_STEP = 16'd320;
	localparam logic [15:0] DEF_DRV_STEP = 16'd4096;
	localparam logic [15:0] TOP_DRIVE = 16'd49152;
	localparam logic [15:0] TOP_CURRENT_RST = 16'd6400;

	// Request codes.
	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// One calibration point.
	typedef struct packed {
		logic [15:0] cur;
		logic [15:0] drv;
	} point_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SORT,
		ST_SCAN,
		ST_MUL,
		ST_DIVL,
		ST_DIVW,
		ST_DONE
	} state_t;

	// Operations of the cell row.
	typedef enum logic [1:0] {
		CH_HOLD,
		CH_LOAD,
		CH_SORT,
		CH_ROT
	} chain_op_t;

	// Control bundle from the controller to the cell row.
	typedef struct packed {
		chain_op_t op;
		logic      cmp_en;
	} chain_ctl_t;

	// Default point k: 20 A and 1 V steps, repeating the top point past ten.
	function automatic point_t default_point(input int k);
		point_t p;
		logic [15:0] n;
		n = (k < DEF_POINTS) ? 16'(k + 1) : 16'(DEF_POINTS);
		p.cur = 16'(n * DEF_CUR_STEP);
		p.drv = 16'(n * DEF_DRV_STEP);
		return p;
	endfunction

endpackage

>>> design/cpld_cell.sv
// ----------------------------------------------------------------------------
// Calibrated piecewise-linear drive: sort cell
// Holds one sorted point and takes a new one from the load bus, its
// neighbor or an alternate source.
// ----------------------------------------------------------------------------
module cpld_cell #(
	parameter logic [31:0] RESET_VAL = '0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpld_pkg::chain_op_t  op,
	input  cpld_pkg::point_t     load_val,
	input  cpld_pkg::point_t     right_val,
	input  cpld_pkg::point_t     alt_val,
	input  logic                 use_alt,
	output cpld_pkg::point_t     q
);

	cpld_pkg::point_t val_q;

	// Load, shift from the neighbor, or take the alternate entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= cpld_pkg::point_t'(RESET_VAL);
		end else begin
			case (op)
				cpld_pkg::CH_LOAD: val_q <= load_val;
				cpld_pkg::CH_SORT,
				cpld_pkg::CH_ROT: val_q <= use_alt ? alt_val : right_val;
				default: val_q <= val_q;
			endcase
		end
	end

	assign q = val_q;

endmodule

>>> design/cpld_chain.sv
// ----------------------------------------------------------------------------
// Calibrated piecewise-linear drive: sorted point row
// A ring of cells. Cell 0 is the holder of an exchange-sort pass; the rest
// stream past it one per cycle. A rotation shows every entry at cell 0.
// ----------------------------------------------------------------------------
module cpld_chain #(
	parameter int N = cpld_pkg::TABLE_POINTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpld_pkg::chain_ctl_t  ctl,
	input  cpld_pkg::point_t      load_pts [N],
	output cpld_pkg::point_t      head
);

	cpld_pkg::point_t cq [N];
	logic swap;
	logic keep;

	// The incoming entry takes the holder place when its current is not larger.
	assign swap = ctl.cmp_en && (cq[1].cur <= cq[0].cur);
	assign keep = (ctl.op == cpld_pkg::CH_SORT) && !swap;

	// Holder cell.
	cpld_cell #(.RESET_VAL(cpld_pkg::default_point(0))) u_cell0 (
		.clk(clk), .arst_n(arst_n), .op(ctl.op), .load_val(load_pts[0]),
		.right_val(cq[1]), .alt_val(cq[0]), .use_alt(keep), .q(cq[0])
	);

	// Middle cells shift toward the holder.
	genvar k;
	generate
		for (k = 1; k < N - 1; k++) begin : g_mid
			cpld_cell #(.RESET_VAL(cpld_pkg::default_point(k))) u_cell (
				.clk(clk), .arst_n(arst_n), .op(ctl.op), .load_val(load_pts[k]),
				.right_val(cq[k + 1]), .alt_val(cq[k + 1]), .use_alt(1'b0),
				.q(cq[k])
			);
		end
	endgenerate

	// Tail cell takes the entry that leaves the holder pass.
	cpld_cell #(.RESET_VAL(cpld_pkg::default_point(N - 1))) u_tail (
		.clk(clk), .arst_n(arst_n), .op(ctl.op), .load_val(load_pts[N - 1]),
		.right_val(cq[0]), .alt_val(cq[1]), .use_alt(keep), .q(cq[N - 1])
	);

	assign head = cq[0];

endmodule

>>> design/cpld_divider.sv
// ----------------------------------------------------------------------------
// Calibrated piecewise-linear drive: divider
// Restoring division, one quotient bit a cycle, for a quotient that is
// known to fit in 16 bits.
// ----------------------------------------------------------------------------
module cpld_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic [15:0] quotient,
	output logic        rem_nz,
	output logic        done
);

	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] div_q;
	logic [3:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[15]};
	assign diff = trial - {1'b0, div_q};

	// Control: sixteen steps, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the high half starts as partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[31:16];
			quo_q <= dividend[15:0];
			div_q <= divisor;
		end else if (run_q) begin
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign rem_nz = (rem_q != 16'd0);
	assign done = done_q;

endmodule

>>> design/calibrated_piecewise_linear_drive_unit.sv
// ----------------------------------------------------------------------------
// Calibrated piecewise-linear drive unit
// Keeps calibration points, sorts them in a cell row and converts a query
// current into a drive value by linear interpolation.
// ----------------------------------------------------------------------------
// From the accepting edge to done: a clear, or a marked add that finds room, loads the
// row, then runs TABLE_POINTS sort passes of TABLE_POINTS steps; a query scans the row
// and, when a pair matches, runs one multiply and the 16-step divider, else goes to done
// straight from the scan; other requests go straight to done.
// One request at a time: busy stays high through done, so the next transfer is taken in the
// cycle after done at the earliest. Done cannot be stalled. Reset loads sorted defaults.
module calibrated_piecewise_linear_drive_unit #(
	parameter int TABLE_POINTS = cpld_pkg::TABLE_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] point_current,
	input  logic [15:0] point_drive,
	input  logic        point_marked,
	input  logic [15:0] query_current,
	output logic        done,
	output logic [15:0] drive_value,
	output logic        status,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int N = TABLE_POINTS;
	localparam int WW = $clog2(N + 1);
	localparam int IW = $clog2(N);
	localparam int SW = $clog2(N + 1);
	localparam logic [WW-1:0] N_W = WW'(N);
	localparam logic [IW-1:0] LAST_I = IW'(N - 1);
	localparam logic [SW-1:0] N_S = SW'(N);

	cpld_pkg::state_t state_q, state_d;
	cpld_pkg::point_t pt_q [N];
	cpld_pkg::point_t head;
	cpld_pkg::point_t prev_q, lo_q, hi_q, lo_c, hi_c;
	cpld_pkg::chain_ctl_t ctl;
	logic [WW-1:0] wr_idx_q;
	logic [15:0]   top_q;
	logic [1:0]    req_q;
	logic [15:0]   qcur_q;
	logic [IW-1:0] pass_q, step_q;
	logic [SW-1:0] scan_q;
	logic          found_q;
	logic          match;
	logic          scan_last;
	logic          accept;
	logic          add_ok;
	logic [15:0]   dq, dd;
	logic          neg;
	logic          neg_s1;
	logic [31:0]   prod_s1;
	logic [15:0]   span;
	logic          div_start;
	logic [15:0]   div_quo;
	logic          div_rem_nz;
	logic          div_done;
	logic [16:0]   quo_adj;
	logic [15:0]   result;
	logic [15:0]   drive_q;
	logic          status_q;

	assign accept = start && !busy;
	assign add_ok = point_marked && (wr_idx_q < N_W);

	// Current pair of the scan: the top end point closes the row.
	assign scan_last = (scan_q == N_S);
	assign lo_c = prev_q;
	assign hi_c = scan_last ? cpld_pkg::point_t'({top_q, cpld_pkg::TOP_DRIVE}) : head;
	assign match = (lo_c.cur <= qcur_q) && (qcur_q <= hi_c.cur) && (hi_c.cur != lo_c.cur);

	// Interpolation operands.
	assign neg = hi_q.drv < lo_q.drv;
	assign dq = qcur_q - lo_q.cur;
	assign dd = neg ? (lo_q.drv - hi_q.drv) : (hi_q.drv - lo_q.drv);
	assign span = hi_q.cur - lo_q.cur;

	// Floor of a negative quotient rounds its magnitude up.
	assign quo_adj = {1'b0, div_quo} + 17'(neg_s1 && div_rem_nz);
	assign result = neg_s1 ? (lo_q.drv - quo_adj[15:0]) : (lo_q.drv + quo_adj[15:0]);

	cpld_chain #(.N(N)) u_chain (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .load_pts(pt_q), .head(head)
	);

	cpld_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod_s1),
		.divisor(span), .quotient(div_quo), .rem_nz(div_rem_nz), .done(div_done)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpld_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cpld_pkg::ST_IDLE: begin
				if (accept) begin
					case (req_type)
						cpld_pkg::REQ_ADD: state_d = add_ok ? cpld_pkg::ST_LOAD : cpld_pkg::ST_DONE;
						cpld_pkg::REQ_CLEAR: state_d = cpld_pkg::ST_LOAD;
						cpld_pkg::REQ_QUERY: state_d = cpld_pkg::ST_SCAN;
						default: state_d = cpld_pkg::ST_DONE;
					endcase
				end
			end
			cpld_pkg::ST_LOAD: state_d = cpld_pkg::ST_SORT;
			cpld_pkg::ST_SORT: begin
				if (step_q == LAST_I && pass_q == LAST_I) begin
					state_d = cpld_pkg::ST_DONE;
				end
			end
			cpld_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = (match || found_q) ? cpld_pkg::ST_MUL : cpld_pkg::ST_DONE;
				end
			end
			cpld_pkg::ST_MUL: state_d = cpld_pkg::ST_DIVL;
			cpld_pkg::ST_DIVL: state_d = cpld_pkg::ST_DIVW;
			cpld_pkg::ST_DIVW: begin
				if (div_done) begin
					state_d = cpld_pkg::ST_DONE;
				end
			end
			cpld_pkg::ST_DONE: state_d = cpld_pkg::ST_IDLE;
			default: state_d = cpld_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		ctl.op = cpld_pkg::CH_HOLD;
		ctl.cmp_en = 1'b0;
		div_start = 1'b0;
		busy = (state_q != cpld_pkg::ST_IDLE);
		done = (state_q == cpld_pkg::ST_DONE);
		case (state_q)
			cpld_pkg::ST_LOAD: ctl.op = cpld_pkg::CH_LOAD;
			cpld_pkg::ST_SORT: begin
				ctl.op = (step_q == LAST_I) ? cpld_pkg::CH_ROT : cpld_pkg::CH_SORT;
				ctl.cmp_en = (step_q < (LAST_I - pass_q));
			end
			cpld_pkg::ST_SCAN: ctl.op = scan_last ? cpld_pkg::CH_HOLD : cpld_pkg::CH_ROT;
			cpld_pkg::ST_DIVL: div_start = 1'b1;
			default: ctl.op = cpld_pkg::CH_HOLD;
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= cpld_pkg::TOP_CURRENT_RST;
		end else if (cfg_we) begin
			top_q <= cfg_wdata;
		end
	end

	// Point table and write index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= N_W;
			for (int k = 0; k < N; k++) begin
				pt_q[k] <= cpld_pkg::default_point(k);
			end
		end else if (accept) begin
			if (req_type == cpld_pkg::REQ_ADD && add_ok) begin
				pt_q[wr_idx_q[IW-1:0]] <= {point_current, point_drive};
				wr_idx_q <= wr_idx_q + WW'(1);
			end else if (req_type == cpld_pkg::REQ_CLEAR) begin
				wr_idx_q <= '0;
				for (int k = 0; k < N; k++) begin
					pt_q[k] <= cpld_pkg::default_point(k);
				end
			end
		end
	end

	// Sort and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
			step_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (accept) begin
				pass_q <= '0;
				step_q <= '0;
				scan_q <= '0;
				found_q <= 1'b0;
			end else if (state_q == cpld_pkg::ST_SORT) begin
				if (step_q == LAST_I) begin
					step_q <= '0;
					pass_q <= pass_q + IW'(1);
				end else begin
					step_q <= step_q + IW'(1);
				end
			end else if (state_q == cpld_pkg::ST_SCAN) begin
				scan_q <= scan_q + SW'(1);
				if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Query datapath: last matching pair wins, then multiply.
	always_ff @(posedge clk) begin
		if (accept) begin
			qcur_q <= query_current;
			req_q <= req_type;
			prev_q <= '0;
		end else if (state_q == cpld_pkg::ST_SCAN) begin
			prev_q <= head;
			if (match) begin
				lo_q <= lo_c;
				hi_q <= hi_c;
			end
		end else if (state_q == cpld_pkg::ST_MUL) begin
			prod_s1 <= 32'(dq) * 32'(dd);
			neg_s1 <= neg;
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
			status_q <= 1'b0;
		end else if (accept) begin
			drive_q <= '0;
			status_q <= (req_type == cpld_pkg::REQ_ADD) && point_marked && !add_ok;
		end else if (state_q == cpld_pkg::ST_DIVW && div_done && req_q == cpld_pkg::REQ_QUERY) begin
			drive_q <= result;
		end
	end

	assign drive_value = drive_q;
	assign status = status_q;

	// The result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held longer than one cycle");

	// A transfer always makes the unit busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("request taken but unit not busy");

	// The write index never passes the table size.
	a_wr_idx: assert property (@(posedge clk) disable iff (!arst_n) wr_idx_q <= N_W)
		else $error("write index beyond table");

	// Full status only answers an add.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (req_q == cpld_pkg::REQ_ADD))
		else $error("full status on a non-add request");

endmodule

>>> tb/sv/tb_calibrated_piecewise_linear_drive_unit.sv
// ----------------------------------------------------------------------------
// Testbench: calibrated piecewise-linear drive unit
// Drives add, clear, query and spare requests through the command port, runs a
// predictor of the calibration tables alongside the block and checks every
// result field against it. A directed table comes first, then random traffic.
// ----------------------------------------------------------------------------
module tb_calibrated_piecewise_linear_drive_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cpld_pkg::*;

	localparam int NPTS = TABLE_POINTS_DEF;
	localparam int NSORT = NPTS + 2;
	localparam int RANDOM_ITEMS = 1500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct packed {
		logic [15:0] drv;
		logic        st;
	} drive_result_t;

	typedef struct {
		logic [1:0]  req;
		logic [15:0] pcur;
		logic [15:0] pdrv;
		logic        mark;
		logic [15:0] qcur;
		logic        known;
		logic [15:0] drv;
		logic        st;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = REQ_ADD;
	logic [15:0] point_current = '0;
	logic [15:0] point_drive = '0;
	logic        point_marked = 1'b0;
	logic [15:0] query_current = '0;
	logic        done;
	logic [15:0] drive_value;
	logic        status;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// Predictor state.
	point_t        cal_points[NPTS];
	point_t        sorted_points[NSORT];
	int            next_slot;
	logic [15:0]   top_cur;
	drive_result_t pending_results[$];
	int            errors = 0;
	int            results_seen = 0;
	int            queries_sent = 0;
	int            idle_cycles = 0;

	calibrated_piecewise_linear_drive_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .point_current(point_current),
		.point_drive(point_drive), .point_marked(point_marked),
		.query_current(query_current), .done(done),
		.drive_value(drive_value), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void load_factory_points();
		for (int k = 0; k < NPTS; k++) begin
			int n;
			n = (k < 10) ? k + 1 : 10;
			cal_points[k].cur = 16'(320 * n);
			cal_points[k].drv = 16'(4096 * n);
		end
	endfunction

	// Frame the points with the end points and order them by exchange sort.
	function automatic void resort_points();
		point_t t;
		sorted_points[0] = '0;
		for (int i = 0; i < NPTS; i++)
			sorted_points[i + 1] = cal_points[i];
		sorted_points[NSORT - 1].cur = top_cur;
		sorted_points[NSORT - 1].drv = TOP_DRIVE;
		for (int i = 1; i <= NPTS; i++)
			for (int j = i; j <= NPTS; j++)
				if (sorted_points[j].cur <= sorted_points[i].cur) begin
					t = sorted_points[j];
					sorted_points[j] = sorted_points[i];
					sorted_points[i] = t;
				end
	endfunction

	// Interpolate over every pair; the highest matching pair wins.
	function automatic logic [15:0] interpolate_drive(logic [15:0] q);
		logic [15:0] res;
		longint span, num, quo;
		point_t lo, hi;
		res = '0;
		for (int i = 0; i + 1 < NSORT; i++) begin
			lo = sorted_points[i];
			hi = sorted_points[i + 1];
			if (lo.cur <= q && q <= hi.cur && hi.cur != lo.cur) begin
				span = longint'(hi.cur) - longint'(lo.cur);
				num = (longint'(q) - longint'(lo.cur)) * (longint'(hi.drv) - longint'(lo.drv));
				quo = num / span;
				if ((num % span) != 0 && num < 0)
					quo -= 1;
				res = 16'(longint'(lo.drv) + quo);
			end
		end
		return res;
	endfunction

	function automatic drive_result_t predict_drive(stim_row_t r);
		drive_result_t o;
		o = '0;
		case (r.req)
			REQ_ADD: begin
				if (r.mark) begin
					if (next_slot >= NPTS) begin
						o.st = 1'b1;
					end else begin
						cal_points[next_slot].cur = r.pcur;
						cal_points[next_slot].drv = r.pdrv;
						next_slot++;
						resort_points();
					end
				end
			end
			REQ_CLEAR: begin
				load_factory_points();
				next_slot = 0;
				resort_points();
			end
			REQ_QUERY: o.drv = interpolate_drive(r.qcur);
			default: ;
		endcase
		return o;
	endfunction

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		drive_result_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: drive_value=%0d status=%0d",
					drive_value, status);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (drive_value !== exp_r.drv) begin
					$error("drive_value: expected %0d, actual %0d", exp_r.drv, drive_value);
					errors++;
				end
				if (status !== exp_r.st) begin
					$error("status: expected %0d, actual %0d", exp_r.st, status);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles with no transfer on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results pending", pending_results.size());
				$display("** calibrated_piecewise_linear_drive_unit: FAILED **");
				$finish;
			end
		end
	end

	int burst_left = 0;

	// Send one request; random gaps between bursts of back-to-back requests.
	task automatic send_request(stim_row_t r);
		drive_result_t p;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req_type <= r.req;
		point_current <= r.pcur;
		point_drive <= r.pdrv;
		point_marked <= r.mark;
		query_current <= r.qcur;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = predict_drive(r);
		if (r.known && (p.drv !== r.drv || p.st !== r.st)) begin
			$error("table row disagrees with predictor: drv %0d/%0d st %0d/%0d",
				r.drv, p.drv, r.st, p.st);
			errors++;
		end
		if (r.req == REQ_QUERY)
			queries_sent++;
		pending_results.push_back(p);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_top_current(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		top_cur = v;
		sorted_points[NSORT - 1].cur = v;
	endtask

	function automatic stim_row_t mk_row(logic [1:0] rq, logic [15:0] pc, logic [15:0] pd,
		logic mk, logic [15:0] qc, logic kn, logic [15:0] dv, logic st);
		stim_row_t r;
		r = '{rq, pc, pd, mk, qc, kn, dv, st};
		return r;
	endfunction

	function automatic stim_row_t random_row(int mode);
		stim_row_t r;
		int sel;
		r = mk_row(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 1'($urandom),
			16'($urandom), 1'b0, 16'd0, 1'b0);
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			r.req = REQ_QUERY;
			// In mode 0, queries mostly fall in the range 0 to 7000.
			if (sel < 35)
				r.qcur = (mode == 0) ? 16'($urandom_range(0, 7000)) : 16'($urandom_range(0, 65535));
		end else if (sel < 80) begin
			r.req = REQ_ADD;
			r.mark = ($urandom_range(0, 9) != 0);
			if (mode == 0)
				r.pcur = 16'($urandom_range(0, 7000));
		end else if (sel < 92) begin
			r.req = REQ_CLEAR;
		end else if (sel < 96) begin
			r.req = REQ_SPARE;
		end else begin
			// Duplicate currents exercise zero-span pairs and tie ordering.
			r.req = REQ_ADD;
			r.mark = 1'b1;
			r.pcur = 16'(320 * $urandom_range(0, 10));
		end
		return r;
	endfunction

	stim_row_t directed_rows[$];
	logic [15:0] top_settings[5] = '{16'd6400, 16'd0, 16'd65535, 16'd1000, 16'd3200};

	initial begin
		top_cur = TOP_CURRENT_RST;
		load_factory_points();
		next_slot = NPTS;
		resort_points();

		// Directed table: reset defaults, extremes, full table, clear, spare code.
		directed_rows = '{
			mk_row(REQ_QUERY, 0, 0, 0, 16'd0, 1, 16'd0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd320, 1, 16'd4096, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd160, 1, 16'd2048, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd3200, 1, 16'd40960, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd6400, 1, 16'd49152, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd65535, 1, 16'd0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd4800, 0, 0, 0),
			mk_row(REQ_ADD, 16'd100, 16'd100, 1, 0, 1, 16'd0, 1),
			mk_row(REQ_ADD, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 1, 16'd0, 0),
			mk_row(REQ_SPARE, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 1, 16'd0, 0),
			mk_row(REQ_CLEAR, 0, 0, 0, 0, 1, 16'd0, 0),
			mk_row(REQ_ADD, 16'hFFFF, 16'hFFFF, 1, 0, 1, 16'd0, 0),
			mk_row(REQ_ADD, 16'd0, 16'hFFFF, 1, 0, 1, 16'd0, 0),
			mk_row(REQ_ADD, 16'd640, 16'd0, 1, 0, 1, 16'd0, 0),
			mk_row(REQ_ADD, 16'd640, 16'd1234, 1, 0, 1, 16'd0, 0),
			mk_row(REQ_ADD, 16'hAAAA, 16'h5555, 1, 0, 1, 16'd0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd0, 0, 0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd640, 0, 0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd500, 0, 0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'd5000, 0, 0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'hFFFF, 0, 0, 0),
			mk_row(REQ_QUERY, 0, 0, 0, 16'h5555, 0, 0, 0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i]);
		drain_results();

		// Random phases, each under its own top current setting.
		for (int ph = 0; ph < 5; ph++) begin
			write_top_current(top_settings[ph]);
			for (int n = 0; n < RANDOM_ITEMS / 5; n++)
				send_request(random_row(ph % 2));
			drain_results();
		end
		write_top_current(16'($urandom));
		for (int n = 0; n < 20; n++)
			send_request(random_row(1));
		drain_results();

		$display("Covered %0d results, %0d of them queries, over six top-current settings.",
			results_seen, queries_sent);
		if (errors == 0)
			$display("** calibrated_piecewise_linear_drive_unit: PASSED **");
		else
			$display("** calibrated_piecewise_linear_drive_unit: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
design/cpld_pkg.sv
design/cpld_cell.sv
design/cpld_chain.sv
design/cpld_divider.sv
design/calibrated_piecewise_linear_drive_unit.sv
tb/sv/tb_calibrated_piecewise_linear_drive_unit.sv
